### src/allele_length_histogram_assert.svh
// ----------------------------------------------------------------------------
// allele length histogram assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ALLELE_LENGTH_HISTOGRAM_ASSERT_SVH
`define ALLELE_LENGTH_HISTOGRAM_ASSERT_SVH

// same-cycle implication, off while reset is low
`define ALH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define ALH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/alh_pkg.sv
// ----------------------------------------------------------------------------
// alh_pkg
// shared constants, types and helpers of the allele length histogram
// ----------------------------------------------------------------------------
package alh_pkg;

    localparam int NUM_BINS    = 512;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int SYM_W       = 8;
    localparam int CNT_W       = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_REF_SYM = 2'd0,
        CMD_ALT_SYM = 2'd1,
        CMD_END     = 2'd2,
        CMD_READ    = 2'd3
    } cmd_e;

    // one queued job for the histogram side; a read carries its bin in all addresses
    typedef struct packed {
        logic             is_end;
        logic             nonbase;
        logic [BIN_W-1:0] ref_addr;
        logic [BIN_W-1:0] alt_addr;
        logic [BIN_W-1:0] sum_addr;
    } q_entry_t;

    function automatic logic is_base(input logic [SYM_W-1:0] ch);
        return ch == 8'h41 || ch == 8'h61 || ch == 8'h43 || ch == 8'h63 ||
               ch == 8'h47 || ch == 8'h67 || ch == 8'h54 || ch == 8'h74;
    endfunction

endpackage

### src/allele_length_histogram.sv
// ----------------------------------------------------------------------------
// allele_length_histogram
// allele length statistics over a stream of variant record characters
// ----------------------------------------------------------------------------
// Items carry a command in s_tuser: a REF or ALT character, an end of
// record, or a bin read. Characters only bump saturating length counters
// and a non-base flag, so any mix of commands streams at one item per
// clock after clearing and while the job queue has room. An end of
// record becomes a read-modify-write of four 512 x 64 histogram memories
// (REF, ALT, REF+ALT, REF+ALT of non-base records) with the previous write
// forwarded, so back-to-back ends hitting the same bin also run at full
// rate. A bin read returns all four bins and both record totals on m_tdata;
// a two-deep result buffer keeps reads at one per clock while m_tready is
// high. A short job queue sits between the character front end and the
// histogram back end. After reset the histograms are zeroed one bin per
// cycle, so s_tready stays low until every bin is cleared.
// ----------------------------------------------------------------------------
module allele_length_histogram (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // symbol[7:0], bin[16:8], zero pad
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [383:0] m_tdata    // ref_count, alt_count, sum_count,
                                    // nonbase_sum_count, total_records,
                                    // nonbase_records, 64 bits each
);

    logic              busy;
    logic              q_full;
    logic              q_push;
    alh_pkg::q_entry_t q_entry;
    logic              q_pop;
    logic              q_head_valid;
    alh_pkg::q_entry_t q_head;

    // character handling and record boundary detection
    alh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .busy     (busy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // job queue decoupling the two halves
    alh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // histogram memories, totals and result buffer
    alh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .busy       (busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### src/alh_queue.sv
// ----------------------------------------------------------------------------
// alh_queue
// short fifo between the record front end and the histogram back end
// ----------------------------------------------------------------------------
module alh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  alh_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output alh_pkg::q_entry_t head
);

    alh_pkg::q_entry_t              entry_reg [alh_pkg::QUEUE_DEPTH];
    logic [alh_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [alh_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [alh_pkg::QPTR_W:0]       count_reg;
    logic [alh_pkg::QPTR_W:0]       count_next;

    assign full       = count_reg == (alh_pkg::QPTR_W+1)'(alh_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/alh_hist_bank.sv
// ----------------------------------------------------------------------------
// alh_hist_bank
// one histogram memory with a read-modify-write increment and forwarding
// ----------------------------------------------------------------------------
module alh_hist_bank (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [alh_pkg::BIN_W-1:0] rd_addr,
    input  logic                      inc_en,
    input  logic                      clr_en,
    input  logic [alh_pkg::BIN_W-1:0] clr_addr,
    output logic [alh_pkg::CNT_W-1:0] count
);

    logic [alh_pkg::CNT_W-1:0] mem [alh_pkg::NUM_BINS];
    logic [alh_pkg::CNT_W-1:0] rdata_reg;
    logic [alh_pkg::BIN_W-1:0] s2_addr_reg;
    logic                      s2_inc_reg;
    logic                      fwd_valid_reg;
    logic [alh_pkg::BIN_W-1:0] fwd_addr_reg;
    logic [alh_pkg::CNT_W-1:0] fwd_data_reg;
    logic [alh_pkg::CNT_W-1:0] cur;
    logic [alh_pkg::CNT_W-1:0] inc_value;
    logic                      wr_en;
    logic [alh_pkg::BIN_W-1:0] wr_addr;
    logic [alh_pkg::CNT_W-1:0] wr_data;

    // the write of the previous cycle has not reached the read data yet
    assign cur       = (fwd_valid_reg && fwd_addr_reg == s2_addr_reg) ? fwd_data_reg
                                                                       : rdata_reg;
    assign inc_value = cur + 1'b1;
    assign count     = cur;

    assign wr_en   = s2_inc_reg || clr_en;
    assign wr_addr = clr_en ? clr_addr : s2_addr_reg;
    assign wr_data = clr_en ? '0 : inc_value;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg    <= mem[rd_addr];
        s2_addr_reg  <= rd_addr;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= inc_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_inc_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s2_inc_reg    <= inc_en;
            fwd_valid_reg <= s2_inc_reg;
        end
    end

endmodule

### src/alh_front.sv
// ----------------------------------------------------------------------------
// alh_front
// takes allele symbols, tracks record lengths and queues histogram jobs
// ----------------------------------------------------------------------------
module alh_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                busy,
    input  logic                q_full,
    output logic                q_push,
    output alh_pkg::q_entry_t   q_entry
);

    logic [alh_pkg::BIN_W-1:0] ref_len_reg;
    logic [alh_pkg::BIN_W-1:0] ref_len_next;
    logic [alh_pkg::BIN_W-1:0] alt_len_reg;
    logic [alh_pkg::BIN_W-1:0] alt_len_next;
    logic                      nonbase_reg;
    logic                      nonbase_next;
    logic [alh_pkg::SYM_W-1:0] symbol;
    logic [alh_pkg::BIN_W-1:0] bin;
    logic [alh_pkg::BIN_W:0]   sum_full;
    logic [alh_pkg::BIN_W-1:0] sum_clamped;
    logic                      accept;
    alh_pkg::cmd_e             cmd;

    localparam logic [alh_pkg::BIN_W-1:0] LAST_BIN = alh_pkg::BIN_W'(alh_pkg::NUM_BINS - 1);

    assign symbol   = s_tdata[alh_pkg::SYM_W-1:0];
    assign bin      = s_tdata[alh_pkg::SYM_W +: alh_pkg::BIN_W];
    assign cmd      = alh_pkg::cmd_e'(s_tuser);
    assign s_tready = !q_full && !busy;
    assign accept   = s_tvalid && s_tready;

    assign sum_full    = {1'b0, ref_len_reg} + {1'b0, alt_len_reg};
    assign sum_clamped = (sum_full >= (alh_pkg::BIN_W+1)'(alh_pkg::NUM_BINS))
                         ? LAST_BIN : sum_full[alh_pkg::BIN_W-1:0];

    always_comb
    begin
        ref_len_next = ref_len_reg;
        alt_len_next = alt_len_reg;
        nonbase_next = nonbase_reg;
        q_push       = 1'b0;
        q_entry      = '{is_end: 1'b0, nonbase: 1'b0,
                         ref_addr: bin, alt_addr: bin, sum_addr: bin};
        if (accept)
        begin
            unique case (cmd)
                alh_pkg::CMD_REF_SYM:
                begin
                    if (ref_len_reg != LAST_BIN)
                    begin
                        ref_len_next = ref_len_reg + 1'b1;
                    end
                    nonbase_next = nonbase_reg || !alh_pkg::is_base(symbol);
                end
                alh_pkg::CMD_ALT_SYM:
                begin
                    if (alt_len_reg != LAST_BIN)
                    begin
                        alt_len_next = alt_len_reg + 1'b1;
                    end
                    nonbase_next = nonbase_reg || !alh_pkg::is_base(symbol);
                end
                alh_pkg::CMD_END:
                begin
                    q_push       = 1'b1;
                    q_entry      = '{is_end: 1'b1, nonbase: nonbase_reg,
                                     ref_addr: ref_len_reg, alt_addr: alt_len_reg,
                                     sum_addr: sum_clamped};
                    ref_len_next = '0;
                    alt_len_next = '0;
                    nonbase_next = 1'b0;
                end
                alh_pkg::CMD_READ:
                begin
                    q_push = 1'b1;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg <= '0;
            alt_len_reg <= '0;
            nonbase_reg <= 1'b0;
        end
        else
        begin
            ref_len_reg <= ref_len_next;
            alt_len_reg <= alt_len_next;
            nonbase_reg <= nonbase_next;
        end
    end

endmodule

### src/alh_back.sv
// ----------------------------------------------------------------------------
// alh_back
// histogram updates, bin reads, record totals and the result buffer
// ----------------------------------------------------------------------------
module alh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  alh_pkg::q_entry_t head,
    output logic              pop,
    output logic              busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [383:0]      m_tdata
);

    localparam int OUT_W = 6 * alh_pkg::CNT_W;

    logic                      clearing_reg;
    logic [alh_pkg::BIN_W-1:0] clr_addr_reg;
    logic [alh_pkg::CNT_W-1:0] total_reg;
    logic [alh_pkg::CNT_W-1:0] nb_total_reg;
    logic                      s2_read_reg;
    logic [alh_pkg::CNT_W-1:0] s2_total_reg;
    logic [alh_pkg::CNT_W-1:0] s2_nb_total_reg;
    logic [OUT_W-1:0]          out_data_reg [2];
    logic [1:0]                out_count_reg;
    logic [1:0]                out_count_next;
    logic                      out_wr_ptr_reg;
    logic                      out_rd_ptr_reg;
    logic                      out_pop;
    logic                      credit_ok;
    logic                      inc_en;
    logic                      nb_inc_en;
    logic [alh_pkg::CNT_W-1:0] ref_cnt;
    logic [alh_pkg::CNT_W-1:0] alt_cnt;
    logic [alh_pkg::CNT_W-1:0] sum_cnt;
    logic [alh_pkg::CNT_W-1:0] nb_sum_cnt;

    assign busy     = clearing_reg;
    assign m_tvalid = out_count_reg != 2'd0;
    assign m_tdata  = out_data_reg[out_rd_ptr_reg];
    assign out_pop  = m_tvalid && m_tready;

    // a read may start only if its result is sure of a buffer slot
    assign credit_ok = ({1'b0, out_count_reg} + 3'(s2_read_reg)) < (3'd2 + 3'(out_pop));
    assign pop       = head_valid && !clearing_reg && (head.is_end || credit_ok);
    assign inc_en    = pop && head.is_end;
    assign nb_inc_en = inc_en && head.nonbase;

    alh_hist_bank u_ref_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (head.ref_addr),
        .inc_en   (inc_en),
        .clr_en   (clearing_reg),
        .clr_addr (clr_addr_reg),
        .count    (ref_cnt)
    );

    alh_hist_bank u_alt_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (head.alt_addr),
        .inc_en   (inc_en),
        .clr_en   (clearing_reg),
        .clr_addr (clr_addr_reg),
        .count    (alt_cnt)
    );

    alh_hist_bank u_sum_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (head.sum_addr),
        .inc_en   (inc_en),
        .clr_en   (clearing_reg),
        .clr_addr (clr_addr_reg),
        .count    (sum_cnt)
    );

    alh_hist_bank u_nb_sum_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (head.sum_addr),
        .inc_en   (nb_inc_en),
        .clr_en   (clearing_reg),
        .clr_addr (clr_addr_reg),
        .count    (nb_sum_cnt)
    );

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s2_read_reg && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !s2_read_reg)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            total_reg      <= '0;
            nb_total_reg   <= '0;
            s2_read_reg    <= 1'b0;
            out_count_reg  <= '0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == alh_pkg::BIN_W'(alh_pkg::NUM_BINS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (inc_en)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (nb_inc_en)
            begin
                nb_total_reg <= nb_total_reg + 1'b1;
            end
            s2_read_reg <= pop && !head.is_end;
            if (s2_read_reg)
            begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_total_reg    <= total_reg;
        s2_nb_total_reg <= nb_total_reg;
        if (s2_read_reg)
        begin
            out_data_reg[out_wr_ptr_reg] <= {s2_nb_total_reg, s2_total_reg,
                                             nb_sum_cnt, sum_cnt, alt_cnt, ref_cnt};
        end
    end

endmodule

### src/alh_checker.sv
// ----------------------------------------------------------------------------
// alh_checker
// port level checks of the allele length histogram
// ----------------------------------------------------------------------------
`include "allele_length_histogram_assert.svh"

module alh_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata
);

    `ALH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
    `ALH_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result item changed while stalled")
    `ALH_ASSERT_NOW(a_nb_total, clk, rst_n, m_tvalid, m_tdata[383:320] <= m_tdata[319:256], "non-base total above record total")
    `ALH_ASSERT_NOW(a_nb_bin, clk, rst_n, m_tvalid, m_tdata[255:192] <= m_tdata[191:128], "non-base bin above sum bin")

endmodule

bind allele_length_histogram alh_checker u_alh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/alh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alh_tb_checker
// watches both streams of the allele length histogram, keeps its own copy of
// the record counters and histograms, and compares every bin read result
// field by field against the counts expected at the time the read was taken
// ----------------------------------------------------------------------------
module alh_tb_checker
    import alh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [23:0]  s_tdata,   // symbol[7:0], bin[16:8], zero pad
    input  logic [1:0]   s_tuser,   // command[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [383:0] m_tdata,   // ref, alt, sum, nonbase sum, totals
    output int           mismatches,
    output int           reads_outstanding
);

    localparam int NUM_FIELDS = 6;
    localparam int MAX_PRINTS = 100;

    // declared top down so the packed layout matches m_tdata, ref_count lowest
    typedef struct packed {
        logic [CNT_W-1:0] nonbase_records;
        logic [CNT_W-1:0] total_records;
        logic [CNT_W-1:0] nonbase_sum_count;
        logic [CNT_W-1:0] sum_count;
        logic [CNT_W-1:0] alt_count;
        logic [CNT_W-1:0] ref_count;
    } bin_report_t;

    logic [CNT_W-1:0] ref_bins     [NUM_BINS];
    logic [CNT_W-1:0] alt_bins     [NUM_BINS];
    logic [CNT_W-1:0] sum_bins     [NUM_BINS];
    logic [CNT_W-1:0] odd_sum_bins [NUM_BINS];
    logic [CNT_W-1:0] records_seen;
    logic [CNT_W-1:0] odd_records;
    logic [BIN_W-1:0] ref_len;
    logic [BIN_W-1:0] alt_len;
    logic             odd_char_seen;

    bin_report_t expected_reads [$];

    // bit 5 folds lower case onto upper case
    function automatic logic is_acgt(input logic [SYM_W-1:0] ch);
        case (ch & 8'hDF) inside
            8'h41, 8'h43, 8'h47, 8'h54: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string field_name(input int f);
        case (f)
            0: return "ref_count";
            1: return "alt_count";
            2: return "sum_count";
            3: return "nonbase_sum_count";
            4: return "total_records";
            default: return "nonbase_records";
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // one accepted item: update the record and histograms, or queue the expected bin read
    task automatic tally_item(input cmd_e command, input logic [SYM_W-1:0] symbol,
                              input logic [BIN_W-1:0] bin);
        int          total_len;
        bin_report_t r;
        case (command) inside
            CMD_REF_SYM, CMD_ALT_SYM:
            begin
                if (command == CMD_REF_SYM)
                begin
                    if (ref_len != NUM_BINS - 1)
                        ref_len = ref_len + 1'b1;
                end
                else if (alt_len != NUM_BINS - 1)
                    alt_len = alt_len + 1'b1;
                if (!is_acgt(symbol))
                    odd_char_seen = 1'b1;
            end
            CMD_END:
            begin
                total_len = int'(ref_len) + int'(alt_len);
                if (total_len > NUM_BINS - 1)
                    total_len = NUM_BINS - 1;
                ref_bins[ref_len]   = ref_bins[ref_len] + 1'b1;
                alt_bins[alt_len]   = alt_bins[alt_len] + 1'b1;
                sum_bins[total_len] = sum_bins[total_len] + 1'b1;
                if (odd_char_seen)
                begin
                    odd_sum_bins[total_len] = odd_sum_bins[total_len] + 1'b1;
                    odd_records = odd_records + 1'b1;
                end
                records_seen  = records_seen + 1'b1;
                ref_len       = '0;
                alt_len       = '0;
                odd_char_seen = 1'b0;
            end
            default:
            begin
                r = '0;
                if (int'(bin) < NUM_BINS)
                begin
                    r.ref_count         = ref_bins[bin];
                    r.alt_count         = alt_bins[bin];
                    r.sum_count         = sum_bins[bin];
                    r.nonbase_sum_count = odd_sum_bins[bin];
                end
                r.total_records   = records_seen;
                r.nonbase_records = odd_records;
                expected_reads.push_back(r);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bin_report_t want;
        int          f;
        if (!rst_n)
        begin
            for (f = 0; f < NUM_BINS; f++)
            begin
                ref_bins[f]     = '0;
                alt_bins[f]     = '0;
                sum_bins[f]     = '0;
                odd_sum_bins[f] = '0;
            end
            records_seen  = '0;
            odd_records   = '0;
            ref_len       = '0;
            alt_len       = '0;
            odd_char_seen = 1'b0;
            expected_reads.delete();
            mismatches    = 0;
            reads_outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                tally_item(cmd_e'(s_tuser), s_tdata[7:0], s_tdata[16:8]);
            if (m_tvalid && m_tready)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch("result with no read waiting", m_tdata[CNT_W-1:0], '0);
                else
                begin
                    want = expected_reads.pop_front();
                    for (f = 0; f < NUM_FIELDS; f++)
                        if (m_tdata[f*CNT_W +: CNT_W] !== want[f*CNT_W +: CNT_W])
                            report_mismatch(field_name(f), m_tdata[f*CNT_W +: CNT_W],
                                            want[f*CNT_W +: CNT_W]);
                end
            end
            reads_outstanding <= expected_reads.size();
        end
    end

endmodule

### sim/allele_length_histogram_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allele_length_histogram_tb
// drives variant record characters, record ends and bin reads into the
// histogram block, with random gaps on the input side and random back
// pressure on the result side; the checker beside the block predicts every
// bin read and this module gives the verdict
// ----------------------------------------------------------------------------
module allele_length_histogram_tb;
    import alh_pkg::*;

    localparam int QUIET_LIMIT  = 4000;  // covers the clearing pass and long stalls
    localparam int DRAIN_CYCLES = 20;    // extra wait once no read is outstanding
    localparam int PHASE_ITEMS  = 150;   // three random phases, about 450 items

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;   // symbol[7:0], bin[16:8], zero pad
    logic [1:0]   s_tuser  = '0;   // command[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [383:0] m_tdata;         // ref, alt, sum, nonbase sum, totals, 64 bits each

    int mismatches;
    int reads_outstanding;

    // stimulus bookkeeping
    bit idle_on = 1'b1;   // random gaps and stalls on both sides
    int items_sent = 0;
    int last_ref = 0;
    int last_alt = 0;
    int last_sum = 0;
    int stall_left = 0;
    int ready_gap;
    int quiet_cycles = 0;

    allele_length_histogram dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alh_tb_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatches        (mismatches),
        .reads_outstanding (reads_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SYM_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0: return 8'h41;   // A
            1: return 8'h61;   // a
            2: return 8'h43;   // C
            3: return 8'h63;   // c
            4: return 8'h47;   // G
            5: return 8'h67;   // g
            6: return 8'h54;   // T
            default: return 8'h74;   // t
        endcase
    endfunction

    // odd_pct: chance in percent of any byte at all instead of a base
    function automatic logic [SYM_W-1:0] pick_symbol(input int odd_pct);
        if ($urandom_range(0, 99) < odd_pct)
            return SYM_W'($urandom_range(0, 255));
        return pick_base();
    endfunction

    // reads aim half the time at bins the last record touched
    function automatic logic [BIN_W-1:0] pick_bin();
        case ($urandom_range(0, 5))
            0: return BIN_W'(last_ref);
            1: return BIN_W'(last_alt);
            2: return BIN_W'(last_sum);
            3: return BIN_W'($urandom_range(0, 15));
            4: return BIN_W'(NUM_BINS - 1);
            default: return BIN_W'($urandom_range(0, NUM_BINS - 1));
        endcase
    endfunction

    // one item on the input stream; returns at the edge that takes it
    task automatic send_item(input cmd_e command, input logic [SYM_W-1:0] symbol,
                             input logic [BIN_W-1:0] bin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bin, symbol};
        s_tuser  <= command;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // unused fields carry random bits
    task automatic send_sym(input cmd_e command, input logic [SYM_W-1:0] symbol);
        send_item(command, symbol, BIN_W'($urandom_range(0, NUM_BINS - 1)));
    endtask

    task automatic send_end();
        send_item(CMD_END, SYM_W'($urandom_range(0, 255)),
                  BIN_W'($urandom_range(0, NUM_BINS - 1)));
    endtask

    task automatic send_read(input logic [BIN_W-1:0] bin);
        send_item(CMD_READ, SYM_W'($urandom_range(0, 255)), bin);
    endtask

    task automatic note_lengths(input int nref, input int nalt);
        last_ref = (nref > NUM_BINS - 1) ? NUM_BINS - 1 : nref;
        last_alt = (nalt > NUM_BINS - 1) ? NUM_BINS - 1 : nalt;
        last_sum = (last_ref + last_alt > NUM_BINS - 1) ? NUM_BINS - 1 : last_ref + last_alt;
    endtask

    // mostly well formed records, some shuffled ones, some plain noise
    task automatic random_record();
        int kind;
        int nref;
        int nalt;
        int odd_pct;
        int k;
        int n;
        kind    = $urandom_range(0, 9);
        nref    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        nalt    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        odd_pct = ($urandom_range(0, 1) == 0) ? 0 : 15;
        if (kind == 0)
        begin
            // noise: any command, any fields
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send_item(cmd_e'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
                          BIN_W'($urandom_range(0, NUM_BINS - 1)));
        end
        else if (kind == 1)
        begin
            // ref and alt characters mixed, reads in between, maybe no end
            for (k = 0; k < nref + nalt; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_read(pick_bin());
                send_sym(($urandom_range(0, 1) == 0) ? CMD_REF_SYM : CMD_ALT_SYM,
                         pick_symbol(odd_pct));
            end
            if ($urandom_range(0, 3) != 0)
                send_end();
        end
        else
        begin
            for (k = 0; k < nref; k++)
                send_sym(CMD_REF_SYM, pick_symbol(odd_pct));
            // a read inside a record must leave the record alone
            if ($urandom_range(0, 9) == 0)
                send_read(pick_bin());
            for (k = 0; k < nalt; k++)
                send_sym(CMD_ALT_SYM, pick_symbol(odd_pct));
            send_end();
            note_lengths(nref, nalt);
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
                send_read(pick_bin());
        end
    endtask

    // result side back pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            ready_gap = pick_gap();
            m_tready   <= (ready_gap == 0);
            stall_left <= (ready_gap > 0) ? ready_gap - 1 : 0;
        end
    end

    // watchdog: too long with nothing taken on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty histograms, lowest and highest bin
        send_read(BIN_W'(0));
        send_read(BIN_W'(NUM_BINS - 1));
        // record with no characters lands in bin 0
        send_end();
        send_read(BIN_W'(0));
        // one base each side, upper and lower case
        send_sym(CMD_REF_SYM, 8'h41);
        send_sym(CMD_ALT_SYM, 8'h74);
        send_end();
        send_read(BIN_W'(1));
        send_read(BIN_W'(2));
        // zero byte and 0xff are non-base; read in the middle of the record
        send_sym(CMD_REF_SYM, 8'h00);
        send_sym(CMD_REF_SYM, 8'h67);
        send_read(BIN_W'(1));
        send_sym(CMD_ALT_SYM, 8'hFF);
        send_end();
        send_read(BIN_W'(2));
        send_read(BIN_W'(1));
        send_read(BIN_W'(3));
        // alt only, 'N' is a non-base letter
        send_sym(CMD_ALT_SYM, 8'h43);
        send_sym(CMD_ALT_SYM, 8'h4E);
        send_end();
        send_read(BIN_W'(0));
        send_read(BIN_W'(2));

        // random records; middle phase runs without gaps or stalls
        for (phase = 0; phase < 3; phase++)
        begin
            idle_on = (phase != 1);
            start   = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_record();
        end
        s_tvalid <= 1'b0;

        // let the checker see the last item, then wait out the reads
        @(posedge clk);
        while (reads_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
